// ===== rtl/homogeneous_point_transform_defines.svh =====
// Assertion macros shared by the homogeneous point transform RTL.
// No dependencies; included by the top level only.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HPT_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HPT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hpt_pkg.sv =====
// Package for the homogeneous point transform: formats, codes, item struct.
// No dependencies.
`timescale 1ns / 1ps

package hpt_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int COEF_FRAC_BITS  = 16;
    localparam int COEF_W          = 18;
    localparam int COORD_W         = 32;
    localparam int ROW_W           = 3 * COEF_W;
    localparam int NUM_REGS        = 8;
    localparam int DATA_W          = 64;
    localparam int REG_IDX_W       = $clog2(NUM_REGS);
    localparam int PADDR_W         = REG_IDX_W + 3;

    localparam int PROD_W  = COEF_W + COORD_W;
    localparam int OFFS_W  = COORD_W + COEF_FRAC_BITS;
    localparam int ACC_W   = ((PROD_W > OFFS_W) ? PROD_W : OFFS_W) + 2;
    localparam int NUM_LOW = COORD_W - COORD_FRAC_BITS;

    localparam int QUO_W          = 32;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

    localparam logic [REG_IDX_W-1:0] REG_LINEAR_ROW0   = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_LINEAR_ROW1   = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_LINEAR_ROW2   = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_PROJECTIVE    = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_X      = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y      = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Z      = REG_IDX_W'(6);
    localparam logic [REG_IDX_W-1:0] REG_W_OFFSET      = REG_IDX_W'(7);

    localparam logic [1:0] FAULT_OK       = 2'd0;
    localparam logic [1:0] FAULT_SAT      = 2'd1;
    localparam logic [1:0] FAULT_ZERO_DIV = 2'd2;

    // rows[0..2] linear, rows[3] projective; offs[0..2] translation, offs[3] w
    typedef struct packed {
        logic [3:0][ROW_W-1:0]   rows;
        logic [3:0][COORD_W-1:0] offs;
    } cfg_t;

    typedef struct packed {
        logic              neg;
        logic              big;
        logic [ACC_W-1:0]  rem;
        logic [QUO_W-1:0]  low;
        logic [QUO_W-1:0]  quo;
    } lane_t;

    typedef struct packed {
        lane_t [2:0]               lane;
        logic [ACC_W-1:0]          dvs;
        logic                      is_pos;
        logic                      zero_div;
        logic [2:0][COORD_W-1:0]   dir_val;
        logic                      dir_sat;
    } item_t;

    typedef struct packed {
        logic [COORD_W-1:0] val;
        logic               sat;
    } clamp_t;

    function automatic clamp_t sat_clamp(input logic neg, input logic [ACC_W-1:0] mag);
        clamp_t r;
        logic [ACC_W-1:0] neg_lim;
        logic [ACC_W-1:0] pos_lim;
        neg_lim = ACC_W'(1) << (COORD_W - 1);
        pos_lim = neg_lim - ACC_W'(1);
        r.sat = 1'b0;
        if (neg) begin
            if (mag > neg_lim) begin
                r.sat = 1'b1;
                r.val = neg_lim[COORD_W-1:0];
            end
            else begin
                r.val = COORD_W'(~mag + ACC_W'(1));
            end
        end
        else begin
            if (mag > pos_lim) begin
                r.sat = 1'b1;
                r.val = pos_lim[COORD_W-1:0];
            end
            else begin
                r.val = mag[COORD_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/hpt_cfg_regs.sv =====
// APB register file for the transform matrix.
// Depends on hpt_pkg.
`timescale 1ns / 1ps

module hpt_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hpt_pkg::PADDR_W-1:0]  paddr,
    input  logic [hpt_pkg::DATA_W-1:0]   pwdata,
    output logic [hpt_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output hpt_pkg::cfg_t                cfg
);

    hpt_pkg::cfg_t cfg_reg;
    logic [hpt_pkg::REG_IDX_W-1:0] idx;
    logic wr_en;

    assign idx    = paddr[hpt_pkg::PADDR_W-1:3];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // identity matrix
            cfg_reg.rows[0] <= hpt_pkg::ROW_W'(1) << hpt_pkg::COEF_FRAC_BITS;
            cfg_reg.rows[1] <= hpt_pkg::ROW_W'(1) << (hpt_pkg::COEF_FRAC_BITS + hpt_pkg::COEF_W);
            cfg_reg.rows[2] <= hpt_pkg::ROW_W'(1)
                               << (hpt_pkg::COEF_FRAC_BITS + 2 * hpt_pkg::COEF_W);
            cfg_reg.rows[3] <= '0;
            cfg_reg.offs[0] <= '0;
            cfg_reg.offs[1] <= '0;
            cfg_reg.offs[2] <= '0;
            cfg_reg.offs[3] <= hpt_pkg::COORD_W'(1) << hpt_pkg::COORD_FRAC_BITS;
        end
        else if (wr_en)
        begin
            case (idx)
                hpt_pkg::REG_LINEAR_ROW0: cfg_reg.rows[0] <= pwdata[hpt_pkg::ROW_W-1:0];
                hpt_pkg::REG_LINEAR_ROW1: cfg_reg.rows[1] <= pwdata[hpt_pkg::ROW_W-1:0];
                hpt_pkg::REG_LINEAR_ROW2: cfg_reg.rows[2] <= pwdata[hpt_pkg::ROW_W-1:0];
                hpt_pkg::REG_PROJECTIVE:  cfg_reg.rows[3] <= pwdata[hpt_pkg::ROW_W-1:0];
                hpt_pkg::REG_OFFSET_X:    cfg_reg.offs[0] <= pwdata[hpt_pkg::COORD_W-1:0];
                hpt_pkg::REG_OFFSET_Y:    cfg_reg.offs[1] <= pwdata[hpt_pkg::COORD_W-1:0];
                hpt_pkg::REG_OFFSET_Z:    cfg_reg.offs[2] <= pwdata[hpt_pkg::COORD_W-1:0];
                hpt_pkg::REG_W_OFFSET:    cfg_reg.offs[3] <= pwdata[hpt_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            hpt_pkg::REG_LINEAR_ROW0: prdata = hpt_pkg::DATA_W'(cfg_reg.rows[0]);
            hpt_pkg::REG_LINEAR_ROW1: prdata = hpt_pkg::DATA_W'(cfg_reg.rows[1]);
            hpt_pkg::REG_LINEAR_ROW2: prdata = hpt_pkg::DATA_W'(cfg_reg.rows[2]);
            hpt_pkg::REG_PROJECTIVE:  prdata = hpt_pkg::DATA_W'(cfg_reg.rows[3]);
            hpt_pkg::REG_OFFSET_X:    prdata = hpt_pkg::DATA_W'(cfg_reg.offs[0]);
            hpt_pkg::REG_OFFSET_Y:    prdata = hpt_pkg::DATA_W'(cfg_reg.offs[1]);
            hpt_pkg::REG_OFFSET_Z:    prdata = hpt_pkg::DATA_W'(cfg_reg.offs[2]);
            hpt_pkg::REG_W_OFFSET:    prdata = hpt_pkg::DATA_W'(cfg_reg.offs[3]);
            default:                  prdata = '0;
        endcase
    end

endmodule

// ===== rtl/hpt_mac.sv =====
// Multiply, sum and divide-setup stages (three register stages).
// Depends on hpt_pkg.
`timescale 1ns / 1ps

module hpt_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  hpt_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    input  logic signed [hpt_pkg::COORD_W-1:0] pos_x,
    input  logic signed [hpt_pkg::COORD_W-1:0] pos_y,
    input  logic signed [hpt_pkg::COORD_W-1:0] pos_z,
    input  logic                              is_position,
    output logic                              item_valid,
    output hpt_pkg::item_t                    item
);

    localparam int AW = hpt_pkg::ACC_W;
    localparam int NL = hpt_pkg::NUM_LOW;

    // stage 1: products
    logic signed [hpt_pkg::PROD_W-1:0]  prod_reg [4][3];
    logic signed [hpt_pkg::COORD_W-1:0] off_reg  [4];
    logic                               pos1_reg;
    logic                               v1_reg;
    // stage 2: sums
    logic signed [AW-1:0]               acc_reg  [4];
    logic                               pos2_reg;
    logic                               v2_reg;
    // stage 3: setup
    hpt_pkg::item_t                     item_reg;
    hpt_pkg::item_t                     item_next;
    logic                               v3_reg;

    logic signed [hpt_pkg::COORD_W-1:0] vec [3];
    assign vec[0] = pos_x;
    assign vec[1] = pos_y;
    assign vec[2] = pos_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= $signed(cfg.rows[r][c*hpt_pkg::COEF_W +: hpt_pkg::COEF_W])
                                      * vec[c];
                end
                off_reg[r] <= is_position ? $signed(cfg.offs[r]) : '0;
            end
            pos1_reg <= is_position;
            for (int r = 0; r < 4; r++)
            begin
                acc_reg[r] <= AW'(prod_reg[r][0]) + AW'(prod_reg[r][1]) + AW'(prod_reg[r][2])
                              + (AW'(off_reg[r]) <<< hpt_pkg::COEF_FRAC_BITS);
            end
            pos2_reg <= pos1_reg;
            item_reg <= item_next;
        end
    end

    // divide setup and direction rounding
    always_comb
    begin
        logic [AW-1:0]      mag;
        logic [AW-1:0]      d;
        logic [AW-1:0]      rnd;
        logic [AW+NL-1:0]   lhs;
        logic [AW+NL-1:0]   rhs;
        hpt_pkg::clamp_t    cl;
        item_next = '0;
        d = acc_reg[3][AW-1] ? AW'(-acc_reg[3]) : AW'(acc_reg[3]);
        item_next.dvs      = d;
        item_next.is_pos   = pos2_reg;
        item_next.zero_div = (acc_reg[3] == '0);
        item_next.dir_sat  = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            mag = acc_reg[i][AW-1] ? AW'(-acc_reg[i]) : AW'(acc_reg[i]);
            lhs = (AW+NL)'(mag);
            rhs = {d, NL'(0)};
            item_next.lane[i].neg = acc_reg[i][AW-1] ^ acc_reg[3][AW-1];
            item_next.lane[i].big = (lhs >= rhs);
            item_next.lane[i].rem = mag >> NL;
            item_next.lane[i].low = {mag[NL-1:0], hpt_pkg::COORD_FRAC_BITS'(0)};
            item_next.lane[i].quo = '0;
            rnd = (mag + (AW'(1) << (hpt_pkg::COEF_FRAC_BITS - 1))) >> hpt_pkg::COEF_FRAC_BITS;
            cl  = hpt_pkg::sat_clamp(acc_reg[i][AW-1], rnd);
            item_next.dir_val[i] = cl.val;
            item_next.dir_sat = item_next.dir_sat | cl.sat;
        end
    end

    assign item_valid = v3_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/hpt_divider.sv =====
// Pipelined restoring divider, three lanes sharing one divisor.
// Depends on hpt_pkg.
`timescale 1ns / 1ps

module hpt_divider (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  hpt_pkg::item_t in_item,
    output logic           out_valid,
    output hpt_pkg::item_t out_item
);

    localparam int N  = hpt_pkg::DIV_STAGES;
    localparam int AW = hpt_pkg::ACC_W;

    hpt_pkg::item_t stage_reg [N];
    logic [N-1:0]   valid_reg;

    function automatic hpt_pkg::item_t div_steps(input hpt_pkg::item_t it);
        hpt_pkg::item_t o;
        logic [AW-1:0] sh;
        o = it;
        for (int s = 0; s < hpt_pkg::BITS_PER_STAGE; s++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sh = {o.lane[i].rem[AW-2:0], o.lane[i].low[hpt_pkg::QUO_W-1]};
                o.lane[i].low = o.lane[i].low << 1;
                if (sh >= o.dvs)
                begin
                    o.lane[i].rem = sh - o.dvs;
                    o.lane[i].quo = {o.lane[i].quo[hpt_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    o.lane[i].rem = sh;
                    o.lane[i].quo = {o.lane[i].quo[hpt_pkg::QUO_W-2:0], 1'b0};
                end
            end
        end
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[N-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg[0] <= div_steps(in_item);
            for (int k = 1; k < N; k++)
                stage_reg[k] <= div_steps(stage_reg[k-1]);
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_item  = stage_reg[N-1];

endmodule

// ===== rtl/homogeneous_point_transform.sv =====
// Top level of the homogeneous 4x4 point transform: ports, output stage, checks.
// Depends on hpt_pkg, hpt_cfg_regs, hpt_mac, hpt_divider and the defines header.
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  input   | in_valid, in_stall, pos_x/y/z, is_position    | in
//  output  | out_valid, out_stall, out_x/y/z, fault        | out
//  config  | psel, penable, pwrite, paddr, pwdata, prdata  | APB
//
// One item per cycle sustained unless out_stall holds a result; items pass hpt_mac, then
// the 2-bits-per-stage restoring divider (16 stages for a 32-bit quotient), then the output register.
// Reset is asynchronous, active low; it clears all valid bits and loads the identity.
// The whole pipeline holds while a result waits under out_stall; in_stall follows.
// Bubbles travel as cleared valid bits and never appear on the output.
`timescale 1ns / 1ps
`include "homogeneous_point_transform_defines.svh"

module homogeneous_point_transform (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [hpt_pkg::COORD_W-1:0] pos_x,
    input  logic signed [hpt_pkg::COORD_W-1:0] pos_y,
    input  logic signed [hpt_pkg::COORD_W-1:0] pos_z,
    input  logic                               is_position,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [hpt_pkg::COORD_W-1:0] out_x,
    output logic signed [hpt_pkg::COORD_W-1:0] out_y,
    output logic signed [hpt_pkg::COORD_W-1:0] out_z,
    output logic [1:0]                         fault,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hpt_pkg::PADDR_W-1:0]        paddr,
    input  logic [hpt_pkg::DATA_W-1:0]         pwdata,
    output logic [hpt_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    localparam int AW = hpt_pkg::ACC_W;

    hpt_pkg::cfg_t  cfg;
    hpt_pkg::item_t mac_item;
    hpt_pkg::item_t div_item;
    logic           mac_valid;
    logic           div_valid;
    logic           adv;

    logic                                  out_valid_reg;
    logic [2:0][hpt_pkg::COORD_W-1:0]      res_reg;
    logic [2:0][hpt_pkg::COORD_W-1:0]      res_next;
    logic [1:0]                            fault_reg;
    logic [1:0]                            fault_next;

    // global pipeline enable: everything moves unless a result is held
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    hpt_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hpt_mac u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .is_position (is_position),
        .item_valid  (mac_valid),
        .item        (mac_item)
    );

    hpt_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (mac_valid),
        .in_item   (mac_item),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    // final stage: round the quotient, clamp, pick direction, position or zero-divisor result
    always_comb
    begin
        logic [AW-1:0]   q;
        logic [AW:0]     rem2;
        logic            rnd;
        logic            any_sat;
        hpt_pkg::clamp_t cl;
        any_sat = 1'b0;
        res_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            rem2 = {div_item.lane[i].rem, 1'b0};
            rnd  = (rem2 >= {1'b0, div_item.dvs});
            q    = AW'(div_item.lane[i].quo) + AW'(rnd);
            if (div_item.lane[i].big)
            begin
                // quotient at least 2^32: always out of range
                cl.sat = 1'b1;
                cl.val = div_item.lane[i].neg ? {1'b1, (hpt_pkg::COORD_W-1)'(0)}
                                              : {1'b0, {(hpt_pkg::COORD_W-1){1'b1}}};
            end
            else
            begin
                cl = hpt_pkg::sat_clamp(div_item.lane[i].neg && (q != '0), q);
            end
            res_next[i] = cl.val;
            any_sat = any_sat | cl.sat;
        end
        if (!div_item.is_pos)
        begin
            res_next   = div_item.dir_val;
            fault_next = div_item.dir_sat ? hpt_pkg::FAULT_SAT : hpt_pkg::FAULT_OK;
        end
        else if (div_item.zero_div)
        begin
            res_next   = '0;
            fault_next = hpt_pkg::FAULT_ZERO_DIV;
        end
        else
        begin
            fault_next = any_sat ? hpt_pkg::FAULT_SAT : hpt_pkg::FAULT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg   <= res_next;
            fault_reg <= fault_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = res_reg[0];
    assign out_y     = res_reg[1];
    assign out_z     = res_reg[2];
    assign fault     = fault_reg;

    // a zero divisor result carries zero coordinates
    `HPT_ASSERT_NOW(a_zero_div_clears, clk, rst_n, out_valid && (fault == hpt_pkg::FAULT_ZERO_DIV), (out_x == '0) && (out_y == '0) && (out_z == '0), "zero divisor item with nonzero output")
    // input is held off only by a waiting result
    `HPT_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid_reg && out_stall, "input stalled without output backpressure")
    // a frozen pipeline keeps the divider and output valid bits in place
    `HPT_ASSERT_NEXT(a_freeze, clk, rst_n, !adv, $stable(div_valid) && $stable(out_valid_reg), "pipeline moved while stalled")

endmodule
